@@ src/three_wire_register_serial_master_defines.svh @@
// assertion macros for the three-wire register serial master
`ifndef THREE_WIRE_REGISTER_SERIAL_MASTER_DEFINES_SVH
`define THREE_WIRE_REGISTER_SERIAL_MASTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TRSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TRSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/trsm_pkg.sv @@
// shared types and constants of the three-wire register serial master
package trsm_pkg;

    localparam int DATA_BITS = 16;
    localparam int CNT_W     = 5;
    localparam int HDR_W     = 9;
    localparam int CODE_W    = 5;
    localparam int OUT_W     = HDR_W + DATA_BITS;

    localparam logic [CNT_W-1:0] HEADER_BITS = CNT_W'(HDR_W);
    localparam logic [CNT_W-1:0] TOTAL_BITS  = CNT_W'(OUT_W);

    // header codes placed above the register index
    localparam logic [CODE_W-1:0] HDR_WRITE = 5'b01100;
    localparam logic [CODE_W-1:0] HDR_READ  = 5'b01110;

    typedef struct packed {
        logic                 req_valid;
        logic                 req_read;
        logic [3:0]           reg_index;
        logic [DATA_BITS-1:0] write_data;
        logic                 sdio_in;
    } t_req;

    typedef struct packed {
        logic                 serial_clock;
        logic                 enable_line;
        logic                 data_out;
        logic                 data_drive;
        logic                 busy_res;
        logic                 read_valid;
        logic [DATA_BITS-1:0] read_data;
    } t_res;

endpackage

@@ src/trsm_if.sv @@
// valid/ready channels for tick words and pin-level result words
interface trsm_req_if;
    logic          valid;
    logic          ready;
    trsm_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface trsm_res_if;
    logic          valid;
    logic          ready;
    trsm_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/three_wire_register_serial_master.sv @@
// three-wire register serial master: one half-bit tick word in, one pin word out
// the result word of a tick is registered and valid in the cycle after the tick is taken
// throughput: one tick per cycle while result words are taken; the result register frees as its word is taken
// a frame is 9 header bits plus 16 data bits, two ticks each, then one closing tick
// reset (synchronous, active low) returns to idle with no result word pending
module three_wire_register_serial_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    trsm_req_if.sink   i_req,
    trsm_res_if.source o_res
);

    logic           advance;
    trsm_pkg::t_res n_res;
    trsm_pkg::t_res r_res;
    logic           r_out_valid;

    // take a tick whenever the result register is empty or draining
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign advance     = i_req.valid && i_req.ready;

    trsm_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_req     (i_req.data),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

endmodule

@@ src/trsm_frame.sv @@
// frame sequencer: phase, bit slot and shift registers, next pin levels
module trsm_frame (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  trsm_pkg::t_req i_req,
    output trsm_pkg::t_res o_res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SHIFT,
        PH_CLOSE
    } t_phase;

    t_phase                           r_phase,     n_phase;
    logic [trsm_pkg::CNT_W-1:0]       r_bit_cnt,   n_bit_cnt;
    logic                             r_half,      n_half;
    logic [trsm_pkg::OUT_W-1:0]       r_out_shift, n_out_shift;
    logic [trsm_pkg::DATA_BITS-1:0]   r_in_shift,  n_in_shift;
    logic                             r_read_mode, n_read_mode;
    logic [trsm_pkg::CNT_W-1:0]       n_pos;
    logic [trsm_pkg::CODE_W-1:0]      hdr_code;

    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_half      = r_half;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_read_mode = r_read_mode;
        hdr_code    = i_req.req_read ? trsm_pkg::HDR_READ : trsm_pkg::HDR_WRITE;
        unique case (r_phase)
            PH_SHIFT: begin
                if (!r_half) begin
                    n_half = 1'b1;
                    // read data slots sample the line on the rising clock
                    if (r_read_mode && (r_bit_cnt >= trsm_pkg::HEADER_BITS)) begin
                        n_in_shift = {r_in_shift[trsm_pkg::DATA_BITS-2:0], i_req.sdio_in};
                    end
                end else begin
                    n_half    = 1'b0;
                    n_bit_cnt = r_bit_cnt + 1'b1;
                    if (n_bit_cnt >= trsm_pkg::TOTAL_BITS) begin
                        n_phase = PH_CLOSE;
                    end
                end
            end
            PH_CLOSE: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_req.req_valid) begin
                    n_read_mode = i_req.req_read;
                    n_out_shift = {hdr_code, i_req.reg_index,
                                   i_req.req_read ? '0 : i_req.write_data};
                    n_bit_cnt   = '0;
                    n_half      = 1'b0;
                    n_in_shift  = '0;
                    n_phase     = PH_SHIFT;
                end
            end
        endcase
    end

    // pin levels after this tick
    always_comb begin
        n_pos = trsm_pkg::TOTAL_BITS - 1'b1 - n_bit_cnt;
        o_res = '0;
        unique case (n_phase)
            PH_SHIFT: begin
                o_res.serial_clock = n_half;
                o_res.enable_line  = 1'b0;
                o_res.busy_res     = 1'b1;
                if (n_read_mode && (n_bit_cnt >= trsm_pkg::HEADER_BITS)) begin
                    o_res.data_drive = 1'b0;
                    o_res.data_out   = 1'b0;
                end else begin
                    o_res.data_drive = 1'b1;
                    o_res.data_out   = n_out_shift[n_pos];
                end
            end
            PH_CLOSE: begin
                o_res.serial_clock = 1'b0;
                o_res.enable_line  = 1'b1;
                o_res.data_drive   = !n_read_mode;
                o_res.busy_res     = 1'b1;
                o_res.read_valid   = n_read_mode;
                o_res.read_data    = n_read_mode ? n_in_shift : '0;
            end
            default: begin
                o_res.serial_clock = 1'b1;
                o_res.enable_line  = 1'b1;
                o_res.data_drive   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_cnt   <= '0;
            r_half      <= 1'b0;
            r_out_shift <= '0;
            r_in_shift  <= '0;
            r_read_mode <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_half      <= n_half;
            r_out_shift <= n_out_shift;
            r_in_shift  <= n_in_shift;
            r_read_mode <= n_read_mode;
        end
    end

endmodule

@@ src/trsm_checker.sv @@
// port-level checks of the three-wire register serial master
`include "three_wire_register_serial_master_defines.svh"

module trsm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input trsm_pkg::t_res i_res
);

    `TRSM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_res), "result word changed while stalled")
    `TRSM_ASSERT_IMP(a_idle_pins, i_clk, i_rst_n, i_out_valid && !i_res.busy_res, i_res.serial_clock && i_res.enable_line && i_res.data_drive && !i_res.data_out && !i_res.read_valid, "idle word does not show idle pins")
    `TRSM_ASSERT_IMP(a_read_close, i_clk, i_rst_n, i_out_valid && i_res.read_valid, i_res.busy_res && i_res.enable_line && !i_res.serial_clock && !i_res.data_drive, "read completion outside a closing tick")
    `TRSM_ASSERT_IMP(a_enable_busy, i_clk, i_rst_n, i_out_valid && !i_res.enable_line, i_res.busy_res && !i_res.read_valid, "enable low outside a frame")
    `TRSM_ASSERT_IMP(a_data_quiet, i_clk, i_rst_n, i_out_valid && !i_res.read_valid, i_res.read_data == '0, "read data shown without completion")

endmodule

bind three_wire_register_serial_master trsm_checker u_trsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_res       (o_res.data)
);
